// File: design/qvca_pkg.sv
// ----------------------------------------------------------------------------
// qvca_pkg
// Shared types, constants and the exponential curve table of the cascaded
// four-channel amplifier.
// ----------------------------------------------------------------------------
package qvca_pkg;

  localparam int SAMPLE_BITS     = 16;
  localparam int CURVE_ADDR_BITS = 8;
  localparam int CHANNELS        = 4;

  localparam int FRAC_BITS     = SAMPLE_BITS - 1;
  localparam int INTERP_BITS   = FRAC_BITS - CURVE_ADDR_BITS;
  localparam int GAIN_W        = 17;
  localparam int FACTOR_W      = FRAC_BITS + 2;
  localparam int CURVE_W       = FRAC_BITS + 1;
  localparam int CURVE_ENTRIES = 1 << CURVE_ADDR_BITS;
  localparam int SG_W          = SAMPLE_BITS + GAIN_W + 1;
  localparam int PROD_W        = SG_W + FACTOR_W + 1;
  localparam int PROD_SHIFT    = 8 + FRAC_BITS;
  localparam int SUM_W         = SAMPLE_BITS + 11;
  localparam int ROUND_BITS    = 8;
  localparam int CELL_LATENCY  = 4;
  localparam int LATENCY       = CHANNELS * CELL_LATENCY;

  localparam int REG_INDEX_W = 3;
  localparam int CFG_DATA_W  = GAIN_W;

  localparam logic [REG_INDEX_W-1:0] REG_GAIN_CH1    = 3'd0;
  localparam logic [REG_INDEX_W-1:0] REG_GAIN_CH2    = 3'd1;
  localparam logic [REG_INDEX_W-1:0] REG_GAIN_CH3    = 3'd2;
  localparam logic [REG_INDEX_W-1:0] REG_GAIN_CH4    = 3'd3;
  localparam logic [REG_INDEX_W-1:0] REG_LINEAR_MASK = 3'd4;
  localparam logic [REG_INDEX_W-1:0] REG_CV_MASK     = 3'd5;
  localparam logic [REG_INDEX_W-1:0] REG_OUT_MASK    = 3'd6;

  localparam logic [GAIN_W-1:0]   GAIN_ONE   = GAIN_W'(65536);
  localparam logic [GAIN_W-1:0]   GAIN_RESET = GAIN_W'(32768);
  localparam logic [FACTOR_W-1:0] FACTOR_ONE = FACTOR_W'(1 << FRAC_BITS);

  localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1 << (ROUND_BITS - 1));
  localparam logic signed [SUM_W-1:0] SAT_HI     = SUM_W'((1 << FRAC_BITS) - 1);
  localparam logic signed [SUM_W-1:0] SAT_LO     = -SUM_W'(1 << FRAC_BITS);

  localparam longint ONE_Q24        = 64'sd16777216;
  localparam longint LN50_Q24       = 64'sd65632855;
  localparam longint CURVE_DEN      = 64'sd49 * ONE_Q24;
  localparam longint CURVE_HALF_DEN = CURVE_DEN / 2;
  localparam longint CURVE_MAX      = 64'sd1 <<< FRAC_BITS;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef sample_t [CHANNELS-1:0] sample_vec_t;
  typedef logic [CURVE_W-1:0] curve_t [CURVE_ENTRIES];

  typedef struct packed {
    sample_vec_t              audio;
    sample_vec_t              control;
    logic signed [SUM_W-1:0]  sum;
    sample_vec_t              results;
  } frame_t;

  typedef struct packed {
    logic [GAIN_W-1:0] gain;
    logic              linear;
    logic              cv_on;
    logic              out_on;
  } ch_cfg_t;

  // Quotient of two nonnegative values by shift and subtract.
  function automatic longint udiv(longint num, longint den);
    longint q;
    longint rem;
    q   = 0;
    rem = 0;
    for (int i = 62; i >= 0; i--) begin
      rem = (rem <<< 1) | ((num >>> i) & 64'sd1);
      if (rem >= den) begin
        rem = rem - den;
        q   = q | (64'sd1 <<< i);
      end
    end
    return q;
  endfunction

  // Entry k is (50^(k/256) - 1)/49 in Q15, from a Q24 series for exp().
  function automatic logic [CURVE_W-1:0] curve_entry(int k);
    longint z;
    longint t;
    longint e;
    longint v;
    z = (longint'(k) * LN50_Q24) >>> CURVE_ADDR_BITS;
    t = ONE_Q24;
    e = ONE_Q24;
    v = 0;
    for (int n = 1; n < 64; n++) begin
      if (t != 0) begin
        t = udiv((t * z) >>> 24, longint'(n));
        e = e + t;
      end
    end
    if (e > ONE_Q24) begin
      v = udiv((e - ONE_Q24) * CURVE_MAX + CURVE_HALF_DEN, CURVE_DEN);
    end
    if (v > CURVE_MAX) begin
      v = CURVE_MAX;
    end
    return v[CURVE_W-1:0];
  endfunction

  function automatic curve_t build_curve(int offset);
    curve_t tbl;
    for (int k = 0; k < CURVE_ENTRIES; k++) begin
      tbl[k] = curve_entry(k + offset);
    end
    return tbl;
  endfunction

  // Lower and upper interpolation points, split so each table has one read.
  localparam curve_t CURVE_LO = build_curve(0);
  localparam curve_t CURVE_HI = build_curve(1);

endpackage

// File: design/quad_vca_cascade_mixer_top.sv
// ----------------------------------------------------------------------------
// quad_vca_cascade_mixer_top
// Four cascaded voltage-controlled amplifier channels with gain, linear or
// exponential CV response and a running sum shared down the chain.
// ----------------------------------------------------------------------------
// A new frame is taken in every clock cycle in which start is high and busy
// is low; busy is high only while rst is held. Each frame gives one result
// transfer, marked by done, after it has passed the four channel cells, each
// of which spends four register stages (curve lookup with the sample-gain
// product, curve interpolation, full product, running sum with rounding and
// saturation).
// The receiver cannot stall, so results must be taken in the cycle that done
// is high. Register writes apply at once and should be made with no frame in
// flight.
module quad_vca_cascade_mixer_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  output logic                                  done,
  input  logic                                  wr_en,
  input  logic [qvca_pkg::REG_INDEX_W-1:0]      wr_index,
  input  logic [qvca_pkg::CFG_DATA_W-1:0]       wr_data,
  input  logic signed [qvca_pkg::SAMPLE_BITS-1:0] audio_ch1,
  input  logic signed [qvca_pkg::SAMPLE_BITS-1:0] audio_ch2,
  input  logic signed [qvca_pkg::SAMPLE_BITS-1:0] audio_ch3,
  input  logic signed [qvca_pkg::SAMPLE_BITS-1:0] audio_ch4,
  input  logic signed [qvca_pkg::SAMPLE_BITS-1:0] control_ch1,
  input  logic signed [qvca_pkg::SAMPLE_BITS-1:0] control_ch2,
  input  logic signed [qvca_pkg::SAMPLE_BITS-1:0] control_ch3,
  input  logic signed [qvca_pkg::SAMPLE_BITS-1:0] control_ch4,
  output logic signed [qvca_pkg::SAMPLE_BITS-1:0] result_ch1,
  output logic signed [qvca_pkg::SAMPLE_BITS-1:0] result_ch2,
  output logic signed [qvca_pkg::SAMPLE_BITS-1:0] result_ch3,
  output logic signed [qvca_pkg::SAMPLE_BITS-1:0] result_ch4
);
  import qvca_pkg::*;

  logic [GAIN_W-1:0]   gain [CHANNELS];
  logic [CHANNELS-1:0] linear_mask;
  logic [CHANNELS-1:0] cv_mask;
  logic [CHANNELS-1:0] out_mask;

  logic   chain_valid [CHANNELS+1];
  frame_t chain_frame [CHANNELS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        gain[i] <= GAIN_RESET;
      end
      linear_mask <= '1;
      cv_mask     <= '0;
      out_mask    <= '1;
    end else if (wr_en) begin
      case (wr_index)
        REG_GAIN_CH1:    gain[0]     <= wr_data;
        REG_GAIN_CH2:    gain[1]     <= wr_data;
        REG_GAIN_CH3:    gain[2]     <= wr_data;
        REG_GAIN_CH4:    gain[3]     <= wr_data;
        REG_LINEAR_MASK: linear_mask <= wr_data[CHANNELS-1:0];
        REG_CV_MASK:     cv_mask     <= wr_data[CHANNELS-1:0];
        REG_OUT_MASK:    out_mask    <= wr_data[CHANNELS-1:0];
        default: ;
      endcase
    end
  end

  assign busy = rst;

  always_comb begin
    chain_valid[0]         = start && !busy;
    chain_frame[0].audio   = {audio_ch4, audio_ch3, audio_ch2, audio_ch1};
    chain_frame[0].control = {control_ch4, control_ch3, control_ch2, control_ch1};
    chain_frame[0].sum     = '0;
    chain_frame[0].results = '0;
  end

  for (genvar i = 0; i < CHANNELS; i++) begin : g_cell
    ch_cfg_t cell_cfg;

    assign cell_cfg.gain   = gain[i];
    assign cell_cfg.linear = linear_mask[i];
    assign cell_cfg.cv_on  = cv_mask[i];
    assign cell_cfg.out_on = out_mask[i];

    qvca_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cfg       (cell_cfg),
      .in_valid  (chain_valid[i]),
      .in_frame  (chain_frame[i]),
      .out_valid (chain_valid[i+1]),
      .out_frame (chain_frame[i+1])
    );
  end

  assign done       = chain_valid[CHANNELS];
  assign result_ch1 = chain_frame[CHANNELS].results[0];
  assign result_ch2 = chain_frame[CHANNELS].results[1];
  assign result_ch3 = chain_frame[CHANNELS].results[2];
  assign result_ch4 = chain_frame[CHANNELS].results[3];

  a_start_gives_done: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LATENCY done)
    else $error("accepted frame produced no result");

  a_done_has_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result with no matching frame");

endmodule

// File: design/qvca_cell.sv
// ----------------------------------------------------------------------------
// qvca_cell
// One channel of the cascade: CV factor, gain and sample products, running
// sum and rounded output, in four register stages.
// ----------------------------------------------------------------------------
module qvca_cell (
  input  logic             clk,
  input  logic             rst,
  input  qvca_pkg::ch_cfg_t cfg,
  input  logic             in_valid,
  input  qvca_pkg::frame_t in_frame,
  output logic             out_valid,
  output qvca_pkg::frame_t out_frame
);
  import qvca_pkg::*;

  logic                            s1_valid;
  frame_t                          s1_frame;
  logic signed [SG_W-1:0]          s1_sg;
  logic [CURVE_W-1:0]              s1_a;
  logic [CURVE_W-1:0]              s1_b;
  logic [INTERP_BITS-1:0]          s1_fr;
  logic [FRAC_BITS-1:0]            s1_x;

  logic                            s2_valid;
  frame_t                          s2_frame;
  logic signed [SG_W-1:0]          s2_sg;
  logic [FACTOR_W-1:0]             s2_f;

  logic                            s3_valid;
  frame_t                          s3_frame;
  logic signed [PROD_W-1:0]        s3_prod;

  logic signed [SAMPLE_BITS-1:0]   smp;
  logic signed [SAMPLE_BITS-1:0]   cv;
  logic [GAIN_W-1:0]               gain_lim;
  logic [FRAC_BITS-1:0]            x_clamp;
  logic [CURVE_ADDR_BITS-1:0]      addr;
  frame_t                          shifted;

  logic signed [CURVE_W:0]                     diff;
  logic signed [CURVE_W+INTERP_BITS+1:0]       slope;
  logic signed [CURVE_W+1:0]                   interp;
  logic [FACTOR_W-1:0]                         f_next;

  logic signed [SUM_W-1:0]         contrib;
  logic signed [SUM_W-1:0]         sum_new;
  logic signed [SUM_W-1:0]         sum_rnd;
  logic signed [SUM_W-1:0]         rounded;
  logic signed [SAMPLE_BITS-1:0]   sat;
  frame_t                          out_next;

  always_comb begin
    smp      = in_frame.audio[0];
    cv       = in_frame.control[0];
    gain_lim = (cfg.gain > GAIN_ONE) ? GAIN_ONE : cfg.gain;
    x_clamp  = cv[SAMPLE_BITS-1] ? '0 : cv[FRAC_BITS-1:0];
    addr     = x_clamp[FRAC_BITS-1:INTERP_BITS];
    shifted  = in_frame;
    shifted.audio   = {{SAMPLE_BITS{1'b0}}, in_frame.audio[CHANNELS-1:1]};
    shifted.control = {{SAMPLE_BITS{1'b0}}, in_frame.control[CHANNELS-1:1]};
  end

  always_comb begin
    diff   = $signed({1'b0, s1_b}) - $signed({1'b0, s1_a});
    slope  = diff * $signed({1'b0, s1_fr});
    interp = $signed({2'b00, s1_a}) + slope[CURVE_W+INTERP_BITS+1:INTERP_BITS];
    if (!cfg.cv_on) begin
      f_next = FACTOR_ONE;
    end else if (cfg.linear) begin
      f_next = {2'b00, s1_x};
    end else begin
      f_next = interp[FACTOR_W-1:0];
    end
  end

  always_comb begin
    contrib = s3_prod[PROD_SHIFT+SUM_W-1:PROD_SHIFT];
    sum_new = s3_frame.sum + contrib;
    sum_rnd = sum_new + ROUND_HALF;
    rounded = sum_rnd >>> ROUND_BITS;
    if (rounded > SAT_HI) begin
      sat = SAT_HI[SAMPLE_BITS-1:0];
    end else if (rounded < SAT_LO) begin
      sat = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      sat = rounded[SAMPLE_BITS-1:0];
    end
    out_next = s3_frame;
    if (cfg.out_on) begin
      out_next.sum     = '0;
      out_next.results = {sat, s3_frame.results[CHANNELS-1:1]};
    end else begin
      out_next.sum     = sum_new;
      out_next.results = {{SAMPLE_BITS{1'b0}}, s3_frame.results[CHANNELS-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_frame  <= shifted;
    s1_sg     <= smp * $signed({1'b0, gain_lim});
    s1_a      <= CURVE_LO[addr];
    s1_b      <= CURVE_HI[addr];
    s1_fr     <= x_clamp[INTERP_BITS-1:0];
    s1_x      <= x_clamp;
    s2_frame  <= s1_frame;
    s2_sg     <= s1_sg;
    s2_f      <= f_next;
    s3_frame  <= s2_frame;
    s3_prod   <= s2_sg * $signed({1'b0, s2_f});
    out_frame <= out_next;
  end

  a_cell_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid |-> ##CELL_LATENCY out_valid)
    else $error("cell dropped a frame");

  a_sum_cleared: assert property (@(posedge clk) disable iff (rst)
    out_valid && cfg.out_on |-> out_frame.sum == '0)
    else $error("connected output left a running sum");

endmodule
